// ----- rtl/hsv_pkg.sv -----
// shared types and constants for the hsv to rgb converter
package hsv_pkg;

  localparam int unsigned HueW  = 15;
  localparam int unsigned FixW  = 17;
  localparam int unsigned ChanW = 8;
  localparam int unsigned FracW = 12;
  localparam int unsigned InnW  = 28;

  localparam logic [HueW-1:0]  FullTurn   = 15'd23040;
  localparam logic [FracW-1:0] SectorSpan = 12'd3840;
  localparam logic [FixW-1:0]  FixOne     = 17'd65536;
  localparam logic [InnW:0]    InnerFull  = 29'd251658240;
  localparam logic [12:0]      Recip15    = 13'd4370;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_e;

  typedef struct packed {
    logic [HueW-1:0] hue;
    logic [FixW-1:0] saturation;
    logic [FixW-1:0] brightness;
  } hsv_in_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_out_t;

  typedef struct packed {
    sector_e          sector;
    logic [FracW-1:0] frac;
    logic [FixW-1:0]  sat;
    logic [FixW-1:0]  val;
  } hsv_work_t;

endpackage

// ----- rtl/hsv_front.sv -----
// front stage: clamps saturation and brightness, zeroes an out-of-range hue and splits hue into sector and fraction
module hsv_front import hsv_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  hsv_in_t   data_i,
  output logic      full_o,
  output logic      valid_o,
  output hsv_work_t work_o,
  input  logic      full_i
);

  logic            fv_q, fv_d;
  hsv_work_t       work_q, work_d;
  logic            adv;
  logic [HueW-1:0] hue_eff;
  logic [HueW-1:0] base;
  sector_e         sector;

  assign adv    = !fv_q || !full_i;
  assign full_o = !adv;

  always_comb begin
    hue_eff = (data_i.hue >= FullTurn) ? '0 : data_i.hue;
    priority if (hue_eff < 15'd3840) begin
      sector = SEC_RED_YEL;
      base   = 15'd0;
    end else if (hue_eff < 15'd7680) begin
      sector = SEC_YEL_GRN;
      base   = 15'd3840;
    end else if (hue_eff < 15'd11520) begin
      sector = SEC_GRN_CYN;
      base   = 15'd7680;
    end else if (hue_eff < 15'd15360) begin
      sector = SEC_CYN_BLU;
      base   = 15'd11520;
    end else if (hue_eff < 15'd19200) begin
      sector = SEC_BLU_MAG;
      base   = 15'd15360;
    end else begin
      sector = SEC_MAG_RED;
      base   = 15'd19200;
    end
    work_d.sector = sector;
    work_d.frac   = FracW'(hue_eff - base);
    work_d.sat    = (data_i.saturation > FixOne) ? FixOne : data_i.saturation;
    work_d.val    = (data_i.brightness > FixOne) ? FixOne : data_i.brightness;
  end

  always_comb begin
    fv_d = fv_q;
    if (adv) begin
      fv_d = push_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else begin
      fv_q <= fv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && push_i) begin
      work_q <= work_d;
    end
  end

  assign valid_o = fv_q;
  assign work_o  = work_q;

endmodule

// ----- rtl/hsv_queue.sv -----
// short fall-through queue between front and back
module hsv_queue import hsv_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  hsv_work_t data_i,
  output logic      full_o,
  input  logic      pop_i,
  output hsv_work_t data_o,
  output logic      empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  hsv_work_t       mem [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_q] <= data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("queue count beyond depth");

  a_cnt_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count missed a push");

  a_cnt_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !do_push) |=> (cnt_q == $past(cnt_q) - 1'b1))
    else $error("queue count missed a pop");

endmodule

// ----- rtl/hsv_back.sv -----
// back pipeline: forms p, q and t terms and places them into channels, or gives grey for zero saturation
module hsv_back import hsv_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  hsv_work_t data_i,
  output logic      take_o,
  output logic      empty_o,
  output rgb_out_t  data_o,
  input  logic      pop_i
);

  logic en;
  logic v1_q, v2_q, v3_q, v4_q;

  // stage 1
  logic [InnW-1:0]  inq1_q, inq1_d, int1_q, int1_d;
  logic [32:0]      pv1_q, pv1_d;
  logic [FixW-1:0]  val1_q;
  logic [ChanW-1:0] vv1_q, vv1_d;
  sector_e          sec1_q;
  logic             zero1_q;
  logic [InnW:0]    sfq, sft;
  logic [FracW-1:0] ft;
  logic [24:0]      v255;

  // stage 2
  logic [44:0]      nq2_q, nq2_d, nt2_q, nt2_d;
  logic [ChanW-1:0] p2_q, p2_d, vv2_q;
  sector_e          sec2_q;
  logic             zero2_q;
  logic [40:0]      pv255;

  // stage 3
  logic [FracW-1:0] xq3_q, xq3_d, xt3_q, xt3_d;
  logic [ChanW-1:0] p3_q, vv3_q;
  sector_e          sec3_q;
  logic             zero3_q;
  logic [52:0]      nq255, nt255;

  // stage 4
  logic [24:0]      qq, tt;
  logic [ChanW-1:0] q4, t4;
  rgb_out_t         out_q, out_d;
  logic             zero4_q;

  assign en      = !v4_q || pop_i;
  assign take_o  = en && valid_i;
  assign empty_o = !v4_q;
  assign data_o  = out_q;

  always_comb begin
    sfq    = 29'(data_i.sat) * 29'(data_i.frac);
    ft     = SectorSpan - data_i.frac;
    sft    = 29'(data_i.sat) * 29'(ft);
    inq1_d = InnW'(InnerFull - sfq);
    int1_d = InnW'(InnerFull - sft);
    pv1_d  = 33'(data_i.val) * 33'(FixOne - data_i.sat);
    v255   = {data_i.val, 8'b0} - 25'(data_i.val);
    vv1_d  = v255[23:16];
  end

  always_comb begin
    nq2_d = 45'(val1_q) * 45'(inq1_q);
    nt2_d = 45'(val1_q) * 45'(int1_q);
    pv255 = {pv1_q, 8'b0} - 41'(pv1_q);
    p2_d  = pv255[39:32];
  end

  always_comb begin
    nq255 = {nq2_q, 8'b0} - 53'(nq2_q);
    nt255 = {nt2_q, 8'b0} - 53'(nt2_q);
    xq3_d = nq255[51:40];
    xt3_d = nt255[51:40];
  end

  always_comb begin
    qq = 25'(xq3_q) * 25'(Recip15);
    tt = 25'(xt3_q) * 25'(Recip15);
    q4 = qq[23:16];
    t4 = tt[23:16];
    if (zero3_q) begin
      out_d = '{red: vv3_q, green: vv3_q, blue: vv3_q};
    end else begin
      unique case (sec3_q)
        SEC_RED_YEL: out_d = '{red: vv3_q, green: t4,    blue: p3_q};
        SEC_YEL_GRN: out_d = '{red: q4,    green: vv3_q, blue: p3_q};
        SEC_GRN_CYN: out_d = '{red: p3_q,  green: vv3_q, blue: t4};
        SEC_CYN_BLU: out_d = '{red: p3_q,  green: q4,    blue: vv3_q};
        SEC_BLU_MAG: out_d = '{red: t4,    green: p3_q,  blue: vv3_q};
        default:     out_d = '{red: vv3_q, green: p3_q,  blue: q4};
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      inq1_q  <= inq1_d;
      int1_q  <= int1_d;
      pv1_q   <= pv1_d;
      val1_q  <= data_i.val;
      vv1_q   <= vv1_d;
      sec1_q  <= data_i.sector;
      zero1_q <= (data_i.sat == '0);
      nq2_q   <= nq2_d;
      nt2_q   <= nt2_d;
      p2_q    <= p2_d;
      vv2_q   <= vv1_q;
      sec2_q  <= sec1_q;
      zero2_q <= zero1_q;
      xq3_q   <= xq3_d;
      xt3_q   <= xt3_d;
      p3_q    <= p2_q;
      vv3_q   <= vv2_q;
      sec3_q  <= sec2_q;
      zero3_q <= zero2_q;
      out_q   <= out_d;
      zero4_q <= zero3_q;
    end
  end

  a_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && zero4_q) |-> (out_q.red == out_q.green && out_q.green == out_q.blue))
    else $error("zero saturation beat is not grey");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && !pop_i) |=> (v4_q && $stable(out_q)))
    else $error("waiting result beat changed");

  a_inner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> (29'(inq1_q) <= InnerFull && 29'(int1_q) <= InnerFull))
    else $error("fraction term out of range");

  a_frac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (xq3_q < 12'(SectorSpan) && xt3_q < 12'(SectorSpan)))
    else $error("scaled term above sector span");

endmodule

// ----- rtl/hsv_to_rgb_converter.sv -----
// top level of the hsv to rgb converter
// path: an accepted push beat passes the front register, the queue and the back stages to the result beat on out_o
// throughput: one beat per cycle while the result beats are popped, set by the fully pipelined back multipliers
// a queue of QUEUE_DEPTH beats between front and back absorbs output stalls
// reset: rst_ni asynchronous active low, clears all valid flags and queue pointers
module hsv_to_rgb_converter import hsv_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  hsv_in_t  in_i,
  output logic     empty,
  input  logic     pop,
  output rgb_out_t out_o
);

  logic      fr_valid, q_full, q_empty, bk_take;
  hsv_work_t fr_work, q_work;

  hsv_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (in_i),
    .full_o  (full),
    .valid_o (fr_valid),
    .work_o  (fr_work),
    .full_i  (q_full)
  );

  hsv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_valid),
    .data_i  (fr_work),
    .full_o  (q_full),
    .pop_i   (bk_take),
    .data_o  (q_work),
    .empty_o (q_empty)
  );

  hsv_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (!q_empty),
    .data_i  (q_work),
    .take_o  (bk_take),
    .empty_o (empty),
    .data_o  (out_o),
    .pop_i   (pop)
  );

endmodule
